### sv/rmf_pkg.sv
// Shared types, constants and codes of the RGB 3x3 median filter.
`default_nettype none

package rmf_pkg;

    // Longest supported image row; the line stores hold one entry per column.
    localparam int MAX_LINE   = 1024;
    localparam int COL_W      = $clog2(MAX_LINE);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int ROW_W      = HEIGHT_W + 1;
    localparam int POS_W      = 22;
    localparam int DIV_CNT_W  = $clog2(POS_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    // Request opcode that flushes the tail of a frame.
    localparam logic OP_DRAIN = 1'b1;

    localparam int WIDTH_RESET_VAL  = 640;
    localparam int HEIGHT_RESET_VAL = 480;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(WIDTH_RESET_VAL);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(HEIGHT_RESET_VAL);
    localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH    = WIDTH_W'(MAX_LINE);
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = HEIGHT_W'(3);

    localparam logic [POS_W-1:0] LAST_POS_RESET =
        POS_W'(WIDTH_RESET_VAL * HEIGHT_RESET_VAL - 1);
    localparam logic [POS_W-1:0] BOT_POS_RESET =
        POS_W'((HEIGHT_RESET_VAL - 1) * WIDTH_RESET_VAL);

    typedef logic [7:0] chan_t;
    // Index 2 is red, 1 is green, 0 is blue.
    typedef chan_t [2:0] pix_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } rmf_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } rmf_out_t;

    // One window column, sorted per channel, plus its unsorted middle pixel.
    typedef struct packed {
        pix_t lo;
        pix_t md;
        pix_t hi;
        pix_t mid_orig;
    } col_t;

    // Index 2 is the newest column, index 1 the center column.
    typedef col_t [2:0] win_t;

    // Frame geometry derived from the configuration registers.
    typedef struct packed {
        logic                busy;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic [POS_W-1:0]    last_pos;
        logic [POS_W-1:0]    bot_pos;
        logic                col_load;
        logic [COL_W-1:0]    col_value;
    } geom_t;

endpackage

`default_nettype wire

### sv/rmf_median_pipe.sv
// Two-stage median-of-nine network over a window of pre-sorted columns.
`default_nettype none

module rmf_median_pipe (
    input  logic          aclk,
    input  logic          load,
    input  rmf_pkg::win_t win,
    output rmf_pkg::pix_t med
);
    import rmf_pkg::*;

    pix_t lo_reg;
    pix_t md_reg;
    pix_t hi_reg;

    function automatic chan_t max8(chan_t a, chan_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic chan_t min8(chan_t a, chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic chan_t med3(chan_t a, chan_t b, chan_t c);
        return max8(min8(a, b), min8(max8(a, b), c));
    endfunction

    // With every column sorted, the median of nine is the median of the
    // largest low, the middle mid and the smallest high.
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int ch = 0; ch < 3; ch++) begin
                lo_reg[ch] <= max8(max8(win[0].lo[ch], win[1].lo[ch]), win[2].lo[ch]);
                md_reg[ch] <= med3(win[0].md[ch], win[1].md[ch], win[2].md[ch]);
                hi_reg[ch] <= min8(min8(win[0].hi[ch], win[1].hi[ch]), win[2].hi[ch]);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            med[ch] = med3(lo_reg[ch], md_reg[ch], hi_reg[ch]);
        end
    end

endmodule

`default_nettype wire

### sv/rmf_cfg_unit.sv
// Configuration registers and the frame geometry recalculation after a write.
`default_nettype none

module rmf_cfg_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [rmf_pkg::POS_W-1:0]       out_pos,
    output rmf_pkg::geom_t                  geom
);
    import rmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MULT = 3'b010,
        ST_DIV  = 3'b100
    } calc_state_t;

    calc_state_t state_reg;
    calc_state_t state_next;

    logic [WIDTH_W-1:0]          width_reg;
    logic [HEIGHT_W-1:0]         height_reg;
    logic [WIDTH_W-1:0]          width_eff;
    logic [HEIGHT_W-1:0]         height_eff;
    logic [WIDTH_W+HEIGHT_W-1:0] area_full;
    logic [POS_W-1:0]            area_reg;
    logic [POS_W-1:0]            last_pos_reg;
    logic [POS_W-1:0]            bot_pos_reg;
    logic [COL_W-1:0]            rem_reg;
    logic [COL_W:0]              rem_shift;
    logic [COL_W-1:0]            rem_next;
    logic [DIV_CNT_W-1:0]        bit_cnt_reg;

    always_comb begin
        if (width_reg < MIN_WIDTH) begin
            width_eff = MIN_WIDTH;
        end else if (width_reg > MAX_WIDTH) begin
            width_eff = MAX_WIDTH;
        end else begin
            width_eff = width_reg;
        end
        height_eff = (height_reg < MIN_HEIGHT) ? MIN_HEIGHT : height_reg;
    end

    assign area_full = (WIDTH_W+HEIGHT_W)'(width_eff) * (WIDTH_W+HEIGHT_W)'(height_eff);

    // Restoring division, one bit of the output position per cycle, to find
    // the output column under the new width.
    assign rem_shift = {rem_reg, out_pos[bit_cnt_reg]};
    assign rem_next  = (rem_shift >= (COL_W+1)'(width_eff))
                     ? COL_W'(rem_shift - (COL_W+1)'(width_eff))
                     : rem_shift[COL_W-1:0];

    always_comb begin
        unique case (state_reg)
            ST_IDLE: begin
                state_next = ST_IDLE;
            end
            ST_MULT: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = (bit_cnt_reg == '0) ? ST_IDLE : ST_DIV;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr_en) begin
            state_next = ST_MULT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            last_pos_reg <= LAST_POS_RESET;
            bot_pos_reg  <= BOT_POS_RESET;
            bit_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg <= cfg_wr_data[WIDTH_W-1:0];
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                    end
                endcase
            end
            if (state_reg == ST_MULT) begin
                bit_cnt_reg <= DIV_CNT_W'(POS_W - 1);
            end
            if (state_reg == ST_DIV) begin
                last_pos_reg <= area_reg - 1'b1;
                bot_pos_reg  <= area_reg - POS_W'(width_eff);
                bit_cnt_reg  <= bit_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MULT) begin
            area_reg <= area_full[POS_W-1:0];
            rem_reg  <= '0;
        end
        if (state_reg == ST_DIV) begin
            rem_reg <= rem_next;
        end
    end

    assign geom.busy      = (state_reg != ST_IDLE);
    assign geom.width     = width_eff;
    assign geom.height    = height_eff;
    assign geom.last_pos  = last_pos_reg;
    assign geom.bot_pos   = bot_pos_reg;
    assign geom.col_load  = (state_reg == ST_DIV) && (bit_cnt_reg == '0);
    assign geom.col_value = rem_next;

endmodule

`default_nettype wire

### sv/rgb_median_3x3_filter_core.sv
// Top level of the streaming RGB 3x3 median filter.
// Pixel requests enter on the s_ channel in raster order; each carries an
// opcode (pixel or drain) and the red, green and blue channels. Results leave
// on the m_ channel in raster order, one line plus one pixel behind the input:
// interior pixels get the per-channel median of their 3x3 neighborhood,
// border pixels pass through, and frame_end marks the last pixel of a frame.
// Drain requests flush the tail of a frame once all of its pixels are in;
// a drain at any other time is taken and dropped.
// A released result passes stages 1, 2 and 3 and the output register before
// m_valid rises. Throughput: one request per cycle while s_ready is high,
// set by the single read-modify-write of the two line memories per pixel.
// The m_ side has an output register and every stage advances on its own,
// so requests keep flowing while a result waits; a stalled receiver fills
// the four stages and then s_ready drops.
// A write on the configuration port (frame_width at index 0, frame_height at
// index 1) recomputes the frame geometry in ST_MULT and ST_DIV, with s_ready low.
// Reset is synchronous and brings back 640 by 480 with an empty pipeline;
// the line memories need no clearing pass.
`default_nettype none

module rgb_median_3x3_filter_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rmf_pkg::rmf_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rmf_pkg::rmf_out_t               m_data,
    input  logic                            cfg_wr_en,
    input  logic [rmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmf_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import rmf_pkg::*;

    geom_t geom;

    // Stream position and output position.
    logic [COL_W-1:0]   in_col_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic               next_started_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [COL_W-1:0]   in_col_next;
    logic [ROW_W-1:0]   in_row_next;
    logic               next_started_next;
    logic [POS_W-1:0]   out_pos_next;
    logic [COL_W-1:0]   out_col_next;

    // Stage 1: line memory data arrives.
    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_idx_reg;
    pix_t               s1_pix_reg;
    logic               s1_emit_reg;
    logic               s1_interior_reg;
    logic               s1_last_reg;
    logic               fwd_reg;
    pix_t               fwd_top_reg;
    pix_t               fwd_mid_reg;
    pix_t               upper_rd_reg;
    pix_t               middle_rd_reg;

    pix_t               upper_mem  [MAX_LINE];
    pix_t               middle_mem [MAX_LINE];

    // Stage 2: window holds the item's neighborhood.
    win_t               win_reg;
    logic               s2_valid_reg;
    logic               s2_interior_reg;
    logic               s2_last_reg;

    // Stage 3: partial medians registered in the median unit.
    logic               s3_valid_reg;
    logic               s3_interior_reg;
    logic               s3_last_reg;
    pix_t               s3_center_reg;

    logic               m_valid_reg;
    rmf_out_t           m_data_reg;

    logic               out_free;
    logic               s3_free;
    logic               s2_free;
    logic               s1_free;
    logic               s1_adv;
    logic               s2_adv;
    logic               s3_adv;
    logic               accept;
    logic               is_drain;
    logic               tail;
    logic               take;
    pix_t               pix_in;
    logic               emit_now;
    logic               next_started_upd;
    logic [WIDTH_W-1:0] col_inc;
    logic               col_wrap;
    logic [COL_W-1:0]   col_after;
    logic [ROW_W-1:0]   row_after;
    logic               interior;
    logic               last_now;
    logic [WIDTH_W-1:0] out_col_inc;
    pix_t               col_top_eff;
    pix_t               col_mid_eff;
    col_t               new_col;
    pix_t               med;
    pix_t               result;

    function automatic col_t sort_column(pix_t top, pix_t mid, pix_t bot);
        col_t  c;
        chan_t a;
        chan_t b;
        chan_t x;
        chan_t t;
        for (int ch = 0; ch < 3; ch++) begin
            a = top[ch];
            b = mid[ch];
            x = bot[ch];
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            if (b > x) begin
                t = b;
                b = x;
                x = t;
            end
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
            c.lo[ch] = a;
            c.md[ch] = b;
            c.hi[ch] = x;
        end
        c.mid_orig = mid;
        return c;
    endfunction

    rmf_cfg_unit u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .out_pos     (out_pos_reg),
        .geom        (geom)
    );

    // Each stage moves on when the next one is empty or moving too.
    assign out_free = !m_valid_reg || m_ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s2_adv   = s2_valid_reg && s3_free;
    assign s3_adv   = s3_valid_reg && out_free;

    assign s_ready  = s1_free && !geom.busy && !cfg_wr_en;
    assign accept   = s_valid && s_ready;
    assign is_drain = (s_data.opcode == OP_DRAIN);

    // The tail is the stretch after the last pixel of the frame being output.
    // A drain only counts there, and only before the next frame has begun.
    assign tail     = (in_row_reg >= ROW_W'(geom.height));
    assign take     = accept && (!is_drain || (tail && !next_started_reg));
    assign pix_in   = is_drain ? '0 : {s_data.red_in, s_data.green_in, s_data.blue_in};

    // The stream must be at least one line plus one pixel ahead of the output.
    assign emit_now = (in_row_reg >= ROW_W'(2))
                   || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0))
                   || ((in_row_reg == '0) && (WIDTH_W'(in_col_reg) > geom.width));

    assign next_started_upd = next_started_reg || (!is_drain && tail);

    assign col_inc   = WIDTH_W'(in_col_reg) + 1'b1;
    assign col_wrap  = (col_inc >= geom.width);
    assign col_after = col_wrap ? '0 : COL_W'(col_inc);
    assign row_after = col_wrap ? in_row_reg + 1'b1 : in_row_reg;

    // Border test on the output position: not the first or last row, not the
    // first or last column.
    assign interior = (out_pos_reg >= POS_W'(geom.width))
                   && (out_pos_reg < geom.bot_pos)
                   && (out_col_reg != '0)
                   && (WIDTH_W'(out_col_reg) <= WIDTH_W'(geom.width - WIDTH_W'(2)));
    assign last_now    = (out_pos_reg >= geom.last_pos);
    assign out_col_inc = WIDTH_W'(out_col_reg) + 1'b1;

    always_comb begin
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        next_started_next = next_started_reg;
        out_pos_next      = out_pos_reg;
        out_col_next      = out_col_reg;
        if (geom.col_load) begin
            out_col_next = geom.col_value;
        end
        if (take) begin
            next_started_next = next_started_upd;
            in_col_next       = col_after;
            in_row_next       = row_after;
            if (emit_now) begin
                if (last_now) begin
                    out_pos_next      = '0;
                    out_col_next      = '0;
                    next_started_next = 1'b0;
                    if (next_started_upd) begin
                        // Pixels of the next frame already in keep their
                        // place, now counted from its first row.
                        in_row_next = (row_after >= ROW_W'(geom.height))
                                    ? row_after - ROW_W'(geom.height) : '0;
                    end else begin
                        in_row_next = '0;
                        in_col_next = '0;
                    end
                end else begin
                    out_pos_next = out_pos_reg + 1'b1;
                    out_col_next = (out_col_inc >= geom.width)
                                 ? '0 : COL_W'(out_col_inc);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            next_started_reg <= 1'b0;
            out_pos_reg      <= '0;
            out_col_reg      <= '0;
        end else begin
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            next_started_reg <= next_started_next;
            out_pos_reg      <= out_pos_next;
            out_col_reg      <= out_col_next;
        end
    end

    // Line memories: read at acceptance, written back when stage 1 moves on.
    // The upper store takes the old middle entry, the middle store the pixel.
    always_ff @(posedge aclk) begin
        if (take) begin
            upper_rd_reg <= upper_mem[in_col_reg];
        end
        if (s1_adv) begin
            upper_mem[s1_idx_reg] <= col_mid_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            middle_rd_reg <= middle_mem[in_col_reg];
        end
        if (s1_adv) begin
            middle_mem[s1_idx_reg] <= s1_pix_reg;
        end
    end

    // When the previous item writes the same column in the same edge as this
    // read (right after a frame end), its write data is forwarded.
    assign col_top_eff = fwd_reg ? fwd_top_reg : upper_rd_reg;
    assign col_mid_eff = fwd_reg ? fwd_mid_reg : middle_rd_reg;
    assign new_col     = sort_column(col_top_eff, col_mid_eff, s1_pix_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_idx_reg      <= in_col_reg;
            s1_pix_reg      <= pix_in;
            s1_emit_reg     <= emit_now;
            s1_interior_reg <= interior;
            s1_last_reg     <= last_now;
            fwd_reg         <= s1_valid_reg && (s1_idx_reg == in_col_reg);
            fwd_top_reg     <= col_mid_eff;
            fwd_mid_reg     <= s1_pix_reg;
        end
    end

    // The window shifts for every item, but only while stage 2 is not
    // holding a neighborhood of its own.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= new_col;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_adv && s1_emit_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_interior_reg <= s1_interior_reg;
            s2_last_reg     <= s1_last_reg;
        end
    end

    rmf_median_pipe u_median (
        .aclk (aclk),
        .load (s2_adv),
        .win  (win_reg),
        .med  (med)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s3_free) begin
                s3_valid_reg <= s2_adv;
            end
            if (out_free) begin
                m_valid_reg <= s3_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            s3_interior_reg <= s2_interior_reg;
            s3_last_reg     <= s2_last_reg;
            s3_center_reg   <= win_reg[1].mid_orig;
        end
    end

    assign result = s3_interior_reg ? med : s3_center_reg;

    always_ff @(posedge aclk) begin
        if (s3_adv) begin
            m_data_reg.red_out   <= result[2];
            m_data_reg.green_out <= result[1];
            m_data_reg.blue_out  <= result[0];
            m_data_reg.frame_end <= s3_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_free |=> s1_valid_reg && $stable(s1_idx_reg)
                                     && $stable(s1_pix_reg))
        else $error("stage 1 item lost while stage 2 was stalled");

    a_fwd_same_col: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s1_valid_reg && (s1_idx_reg == in_col_reg) |=> fwd_reg)
        else $error("same-column read not forwarded");

    a_window_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && !s3_free |=> $stable(win_reg))
        else $error("window changed under a stalled stage 2 item");

    a_out_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !geom.busy |-> (WIDTH_W'(out_col_reg) < geom.width))
        else $error("output column outside the frame width");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        take && emit_now && last_now |=> (out_pos_reg == '0))
        else $error("output position not cleared after frame end");
`endif

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the streaming RGB 3x3 median filter core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rmf_pkg::*;

    // Opcode of a request that carries a new pixel.
    localparam logic OP_PIXEL = ~OP_DRAIN;

    // How the channels of a pixel are chosen. Rails and narrow values give
    // many equal neighbors, so ties inside the median sort get exercised.
    typedef enum logic [1:0] {PIX_ANY, PIX_RAILS, PIX_NARROW} pix_style_e;

    // How the stimulus leaves a frame: flushed by drain requests, pushed out
    // by the next frame's pixels, or drained part way and then pushed out.
    typedef enum logic [1:0] {TAIL_FLUSH, TAIL_PUSH, TAIL_PARTIAL} tail_e;

    // The scoreboard keeps its own copy of the filter state. Every accepted
    // request is run through it, and the pixel that the request releases,
    // if any, is queued until the core delivers its result.
    class median_scoreboard;
        logic [WIDTH_W-1:0]  width_reg;
        logic [HEIGHT_W-1:0] height_reg;
        logic [23:0]         upper_line [MAX_LINE];
        logic [23:0]         middle_line [MAX_LINE];
        logic [23:0]         window [9];
        int unsigned         in_col;
        int unsigned         in_row;
        int unsigned         out_pos;
        bit                  next_frame_begun;
        rmf_out_t            expected_pixels [$];
        int                  mismatches;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            in_col           = 0;
            in_row           = 0;
            out_pos          = 0;
            next_frame_begun = 1'b0;
            mismatches       = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] index, input int value);
            if (index == CFG_FRAME_WIDTH) begin
                width_reg = WIDTH_W'(value);
            end else begin
                height_reg = HEIGHT_W'(value);
            end
        endfunction

        function int unsigned eff_width();
            if (width_reg < MIN_WIDTH) return int'(MIN_WIDTH);
            if (width_reg > MAX_WIDTH) return MAX_LINE;
            return int'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg < MIN_HEIGHT) return int'(MIN_HEIGHT);
            return int'(height_reg);
        endfunction

        // Fifth smallest of the nine window values of one channel.
        function chan_t median_of(input int shift);
            chan_t v [9];
            chan_t t;
            for (int i = 0; i < 9; i++) v[i] = window[i][shift +: 8];
            for (int i = 0; i < 8; i++) begin
                for (int j = 0; j < 8 - i; j++) begin
                    if (v[j] > v[j + 1]) begin
                        t        = v[j];
                        v[j]     = v[j + 1];
                        v[j + 1] = t;
                    end
                end
            end
            return v[4];
        endfunction

        function void take_request(input rmf_in_t req);
            int unsigned     w;
            int unsigned     h;
            int unsigned     idx;
            int unsigned     orow;
            int unsigned     ocol;
            longint unsigned pos;
            logic [23:0]     pix;
            logic [23:0]     col_top;
            logic [23:0]     col_mid;
            rmf_out_t        res;
            bit              emit;
            bit              last;
            w   = eff_width();
            h   = eff_height();
            pix = '0;
            if (req.opcode == OP_DRAIN) begin
                // A drain only counts while the tail of a frame is pending.
                if (!(in_row >= h && !next_frame_begun)) return;
            end else begin
                pix = {req.red_in, req.green_in, req.blue_in};
                if (in_row >= h) next_frame_begun = 1'b1;
            end
            idx              = (in_col < MAX_LINE) ? in_col : MAX_LINE - 1;
            col_top          = upper_line[idx];
            col_mid          = middle_line[idx];
            upper_line[idx]  = col_mid;
            middle_line[idx] = pix;
            for (int r = 0; r < 3; r++) begin
                window[r * 3]     = window[r * 3 + 1];
                window[r * 3 + 1] = window[r * 3 + 2];
            end
            window[2] = col_top;
            window[5] = col_mid;
            window[8] = pix;

            pos  = longint'(in_row) * w + in_col;
            emit = (pos >= w + 1);
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (!emit) return;

            orow = out_pos / w;
            ocol = out_pos % w;
            res.red_out   = window[4][23:16];
            res.green_out = window[4][15:8];
            res.blue_out  = window[4][7:0];
            if (orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2) begin
                res.red_out   = median_of(16);
                res.green_out = median_of(8);
                res.blue_out  = median_of(0);
            end
            last          = (out_pos >= h * w - 1);
            res.frame_end = last;
            expected_pixels.push_back(res);

            if (last) begin
                out_pos = 0;
                if (next_frame_begun) begin
                    in_row = (in_row >= h) ? in_row - h : 0;
                end else begin
                    in_row = 0;
                    in_col = 0;
                end
                next_frame_begun = 1'b0;
            end else begin
                out_pos++;
            end
        endfunction

        function void flag(input string what, input rmf_out_t want, input rmf_out_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected %h %h %h end=%0b, actual %h %h %h end=%0b",
                         $time, what, want.red_out, want.green_out, want.blue_out,
                         want.frame_end, got.red_out, got.green_out, got.blue_out,
                         got.frame_end);
        endfunction

        function void check_pixel(input rmf_out_t got);
            rmf_out_t want;
            if (expected_pixels.size() == 0) begin
                flag("result with nothing pending", '0, got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out || got.frame_end !== want.frame_end)
                flag("pixel mismatch", want, got);
        endfunction
    endclass

    // Clock, reset and every input of the core start at known values.
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    rmf_in_t               s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    rmf_out_t              m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    median_scoreboard sb = new();

    // Percent of cycles in which each side holds back, set per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // A long receiver hold-off is requested by the stimulus and counted down
    // by the receiver process itself.
    int stall_request = 0;
    int stall_left    = 0;
    int requests_sent = 0;

    always #4 aclk = ~aclk;

    rgb_median_3x3_filter_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // Receiver: ready changes on the falling edge only. During a long
    // hold-off the core keeps taking requests until its stages are full,
    // after which s_ready has to drop.
    always @(negedge aclk) begin
        if (stall_request != 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Results are taken at the rising edge where valid and ready meet.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_pixel(m_data);
    end

    // Offers one request, with random idle cycles ahead of it, and holds it
    // until the core accepts it. Entered and left at a falling edge, so the
    // valid line sees at most one update per time step.
    task automatic send_request(input rmf_in_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.take_request(req);
        requests_sent++;
        @(negedge aclk);
    endtask

    function automatic chan_t pick_chan(input pix_style_e style);
        case (style)
            PIX_RAILS:  return $urandom_range(1) ? 8'hFF : 8'h00;
            PIX_NARROW: return chan_t'(8'h7E + $urandom_range(3));
            default:    return chan_t'($urandom_range(255));
        endcase
    endfunction

    task automatic send_pixel(input pix_style_e style);
        rmf_in_t req;
        req.opcode   = OP_PIXEL;
        req.red_in   = pick_chan(style);
        req.green_in = pick_chan(style);
        req.blue_in  = pick_chan(style);
        send_request(req);
    endtask

    // Drain channels are ignored by the core but still toggle at random.
    task automatic send_drain();
        rmf_in_t req;
        req.opcode   = OP_DRAIN;
        req.red_in   = chan_t'($urandom_range(255));
        req.green_in = chan_t'($urandom_range(255));
        req.blue_in  = chan_t'($urandom_range(255));
        send_request(req);
    endtask

    // Waits until every predicted pixel has come out, then gives the core a
    // few more cycles before the next step.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // A write makes the core recompute its geometry with s_ready low, so the
    // next write waits until the core takes requests again.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_register(index, value);
        repeat (2) @(negedge aclk);
        while (!s_ready) @(negedge aclk);
    endtask

    // Streams back-to-back frames at the current geometry. Between frames
    // the tail is flushed, pushed out, or partly drained; the last frame is
    // always flushed so the core ends empty. Stray drains are mixed in only
    // where the core must drop them: after the first real pixel of a frame.
    task automatic run_chain(input int frames, input pix_style_e style, input int noise_pct);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        int unsigned first_slot;
        int unsigned k;
        tail_e       tail;
        w          = sb.eff_width();
        h          = sb.eff_height();
        first_slot = 0;
        for (int f = 0; f < frames; f++) begin
            slot = first_slot;
            while (slot < w * h) begin
                if (slot > first_slot && $urandom_range(99) < noise_pct) send_drain();
                send_pixel(style);
                slot++;
            end
            first_slot = 0;
            tail = (f == frames - 1) ? TAIL_FLUSH : tail_e'($urandom_range(2));
            case (tail)
                TAIL_FLUSH: begin
                    // One line plus one pixel of drains ends the frame; any
                    // extra drain after that is dropped.
                    repeat (w + 1 + $urandom_range(1)) send_drain();
                end
                TAIL_PARTIAL: begin
                    // The drained slots become the first, zero pixels of
                    // the next frame.
                    k = $urandom_range(w, 1);
                    repeat (k) send_drain();
                    first_slot = k;
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic configure(input int width_val, input int height_val);
        wait_quiet();
        write_register(CFG_FRAME_WIDTH, width_val);
        write_register(CFG_FRAME_HEIGHT, height_val);
    endtask

    // Smallest frame, with register values below the clamp: a drain with
    // nothing pending, rail and mid-range pixels, a partly drained tail
    // followed by pixels, and a tail flushed by drains with one to spare.
    task automatic directed_frames();
        rmf_in_t req;
        configure(0, 0);
        send_drain();
        for (int i = 0; i < 9; i++) begin
            req.opcode   = OP_PIXEL;
            req.red_in   = (i == 8) ? 8'hFF : chan_t'(i * 31);
            req.green_in = 8'hFF - chan_t'(i * 29);
            req.blue_in  = i[0] ? 8'hFF : 8'h00;
            send_request(req);
        end
        repeat (2) send_drain();
        repeat (7) send_pixel(PIX_RAILS);
        repeat (5) send_drain();
    endtask

    // Random geometries, mostly small; a few land below the clamp.
    task automatic random_frames(input int budget);
        int stop_at;
        stop_at = requests_sent + budget;
        while (requests_sent < stop_at) begin
            configure(($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(16),
                      ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(6));
            run_chain($urandom_range(3, 1), pix_style_e'($urandom_range(2)), 10);
        end
    endtask

    // Stimulus runs in three phases: a fast sender with a busy receiver,
    // the reverse, and then full rate with a long receiver hold-off.
    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 86;
        directed_frames();
        random_frames(300);

        send_idle_pct = 86;
        recv_idle_pct = 20;
        random_frames(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(16, 8);
        stall_request = 300;
        run_chain(2, PIX_ANY, 5);
        random_frames(300);

        // A tall frame on the narrowest line.
        configure(3, 40);
        run_chain(1, PIX_ANY, 2);

        wait_quiet();
        repeat (16) @(negedge aclk);
        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Far beyond the slowest correct run, including every stall.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
